// ===== sv/ps2_mouse_packet_to_cursor_core_macros.svh =====
// assertion macros used by the mouse packet decoder controller
`ifndef PS2_MOUSE_PACKET_TO_CURSOR_CORE_MACROS_SVH
`define PS2_MOUSE_PACKET_TO_CURSOR_CORE_MACROS_SVH
`ifndef ASSERT_OFF
`define PS2MC_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define PS2MC_NEVER(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define PS2MC_ASSERT(lbl, clk, rst, prop, msg)
`define PS2MC_NEVER(lbl, clk, rst, expr, msg)
`endif
`endif

// ===== sv/ps2mc_pkg.sv =====
// shared types, constants and width helpers of the mouse packet decoder
`timescale 1ns / 1ps
package ps2mc_pkg;
  localparam int POS_BITS_DEF = 12;
  localparam int SPEED_FRAC_DEF = 8;
  localparam int CFG_W = 12;
  localparam int OUT_POS_W = 12;

  localparam logic [7:0]  RST_ACCEL_NUM = 8'd2;
  localparam logic [7:0]  RST_ACCEL_DEN = 8'd1;
  localparam logic [7:0]  RST_ACCEL_THR = 8'd4;
  localparam logic [11:0] RST_SCREEN_W = 12'd640;
  localparam logic [11:0] RST_SCREEN_H = 12'd480;

  typedef enum logic [2:0] {
    REG_ACCEL_NUM = 3'd0,
    REG_ACCEL_DEN = 3'd1,
    REG_ACCEL_THR = 3'd2,
    REG_SCREEN_W  = 3'd3,
    REG_SCREEN_H  = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    EV_MOTION = 2'd0,
    EV_DOWN   = 2'd1,
    EV_UP     = 2'd2
  } event_kind_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_HDR, OP_DXB, OP_DYB, OP_SQX, OP_SQY, OP_RTI, OP_RTS,
    OP_NUM1, OP_NUM2, OP_MUL, OP_DVI, OP_DVS, OP_UPD, OP_CLAMP, OP_BTN
  } dp_op_t;

  typedef struct packed {
    dp_op_t      op;
    logic        axis;      // 0 = x, 1 = y
    logic        load_out;
    event_kind_t kind;
    logic        last;
  } dp_cmd_t;

  typedef struct packed {
    logic zero_motion;
    logic btn_change;
    logic btn_new;      // left button level of the held packet header
    logic moved;
  } dp_stat_t;

  // square root iterations (one result bit each)
  function automatic int rt_steps(int f);
    return 9 + f;
  endfunction

  // width of the scaled product, also the divider step count
  function automatic int prod_bits(int f);
    return 29 + f;
  endfunction
endpackage

// ===== sv/ps2mc_datapath.sv =====
// datapath: config registers, packet bytes, square root, multiply, divide, position
`timescale 1ns / 1ps
module ps2mc_datapath
  import ps2mc_pkg::*;
#(
  parameter int POS_BITS = POS_BITS_DEF,
  parameter int SPEED_FRAC_BITS = SPEED_FRAC_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic [7:0]       in_byte,
  input  dp_cmd_t          cmd,
  output dp_stat_t         stat,
  output logic [1:0]       out_kind,
  output logic [11:0]      out_x,
  output logic [11:0]      out_y,
  output logic             out_btn,
  output logic             out_last
);
  localparam int F = SPEED_FRAC_BITS;
  localparam int XW = (POS_BITS > OUT_POS_W) ? POS_BITS : OUT_POS_W;
  localparam int VW = 18 + 2 * F;
  localparam int SPW = rt_steps(F);
  localparam int DDW = 17 + F;
  localparam int NW = 19 + F;
  localparam int MW = prod_bits(F);
  localparam logic [XW-1:0] TOP = XW'((64'd1 << POS_BITS) - 64'd1);

  logic [7:0] accel_num, accel_den, accel_thr;
  logic [11:0] screen_w, screen_h;
  logic [7:0] hdr, dxb, dyb;
  logic button_held;
  logic [XW-1:0] pos_x, pos_y;
  logic [17:0] sq;
  logic [VW-1:0] rt_v, rt_res, rt_bit;
  logic [DDW-1:0] dd;
  logic signed [NW-1:0] nprod, numer;
  logic signed [MW-1:0] mp;
  logic [MW-1:0] dvd;
  logic [DDW-1:0] rem;
  logic neg;

  // decoded motion
  logic signed [9:0] dx, dy, dsel;
  logic [7:0] den_e, thr_e;
  logic [XW-1:0] lim_x, lim_y, cx, cy, lim_sel, pos_sel, upd_val;
  logic [VW:0] rt_sum;
  logic [DDW:0] rs;
  logic signed [MW+1:0] pos_ext, q_ext, upd_sum;
  logic signed [8:0] adiff;

  always_comb begin
    dx = 10'(signed'({hdr[4], dxb}));
    dy = -10'(signed'({hdr[5], dyb}));
    dsel = cmd.axis ? dy : dx;
    den_e = (accel_den == 8'd0) ? 8'd1 : accel_den;
    thr_e = (accel_thr == 8'd0) ? 8'd1 : accel_thr;
    adiff = signed'({1'b0, accel_num}) - signed'({1'b0, den_e});
    lim_x = (XW'(screen_w) > TOP) ? TOP : XW'(screen_w);
    lim_y = (XW'(screen_h) > TOP) ? TOP : XW'(screen_h);
    cx = (pos_x > lim_x) ? lim_x : pos_x;
    cy = (pos_y > lim_y) ? lim_y : pos_y;
    rt_sum = {1'b0, rt_res} + {1'b0, rt_bit};
    rs = {rem, dvd[MW-1]};
    // signed position update with clamp
    lim_sel = cmd.axis ? lim_y : lim_x;
    pos_sel = cmd.axis ? pos_y : pos_x;
    pos_ext = signed'({{(MW+2-XW){1'b0}}, pos_sel});
    q_ext = signed'({2'b00, dvd});
    upd_sum = neg ? (pos_ext - q_ext) : (pos_ext + q_ext);
    if (upd_sum < 0) begin
      upd_val = '0;
    end else if (upd_sum > signed'({{(MW+2-XW){1'b0}}, lim_sel})) begin
      upd_val = lim_sel;
    end else begin
      upd_val = upd_sum[XW-1:0];
    end
    stat.zero_motion = (dx == 10'sd0) && (dy == 10'sd0);
    stat.btn_change = hdr[0] != button_held;
    stat.btn_new = hdr[0];
    stat.moved = (cx != pos_x) || (cy != pos_y);
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      accel_num <= RST_ACCEL_NUM;
      accel_den <= RST_ACCEL_DEN;
      accel_thr <= RST_ACCEL_THR;
      screen_w <= RST_SCREEN_W;
      screen_h <= RST_SCREEN_H;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_ACCEL_NUM: accel_num <= cfg_data[7:0];
        REG_ACCEL_DEN: accel_den <= cfg_data[7:0];
        REG_ACCEL_THR: accel_thr <= cfg_data[7:0];
        REG_SCREEN_W: screen_w <= cfg_data;
        REG_SCREEN_H: screen_h <= cfg_data;
        default: ;
      endcase
    end
  end

  // packet state, position and button
  always_ff @(posedge clk) begin
    if (rst) begin
      hdr <= '0;
      dxb <= '0;
      button_held <= 1'b0;
      pos_x <= XW'(RST_SCREEN_W >> 1);
      pos_y <= XW'(RST_SCREEN_H >> 1);
    end else begin
      unique case (cmd.op)
        OP_HDR: hdr <= in_byte;
        OP_DXB: dxb <= in_byte;
        OP_UPD: begin
          if (cmd.axis) pos_y <= upd_val;
          else pos_x <= upd_val;
        end
        OP_CLAMP: begin
          pos_x <= cx;
          pos_y <= cy;
        end
        OP_BTN: button_held <= hdr[0];
        default: ;
      endcase
    end
  end

  // arithmetic working registers
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_DYB: dyb <= in_byte;
      OP_SQX: begin
        sq <= 18'(dx * dx);
        dd <= {{8'd0, den_e} * {8'd0, thr_e}, 1'b0, {F{1'b0}}};
      end
      OP_SQY: sq <= sq + 18'(dy * dy);
      OP_RTI: begin
        rt_v <= {sq, {(2*F){1'b0}}};
        rt_res <= '0;
        rt_bit <= VW'(1) << (VW - 2);
      end
      OP_RTS: begin
        if ({1'b0, rt_v} >= rt_sum) begin
          rt_v <= rt_v - rt_sum[VW-1:0];
          rt_res <= (rt_res >> 1) + rt_bit;
        end else begin
          rt_res <= rt_res >> 1;
        end
        rt_bit <= rt_bit >> 2;
      end
      OP_NUM1: nprod <= NW'(adiff * signed'({1'b0, rt_res[SPW-1:0]}));
      OP_NUM2: numer <= signed'({2'b00, dd}) + nprod;
      OP_MUL: mp <= MW'(dsel * numer);
      OP_DVI: begin
        neg <= mp[MW-1];
        dvd <= mp[MW-1] ? MW'(-mp) : MW'(mp);
        rem <= '0;
      end
      OP_DVS: begin
        if (rs >= {1'b0, dd}) begin
          rem <= DDW'(rs - {1'b0, dd});
          dvd <= {dvd[MW-2:0], 1'b1};
        end else begin
          rem <= rs[DDW-1:0];
          dvd <= {dvd[MW-2:0], 1'b0};
        end
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_kind <= cmd.kind;
      out_x <= pos_x[11:0];
      out_y <= pos_y[11:0];
      out_btn <= (cmd.kind == EV_MOTION) ? button_held : hdr[0];
      out_last <= cmd.last;
    end
  end
endmodule

// ===== sv/ps2mc_ctrl.sv =====
// controller: packet byte count, step sequencing and result handshake
`timescale 1ns / 1ps
`include "ps2_mouse_packet_to_cursor_core_macros.svh"
module ps2mc_ctrl
  import ps2mc_pkg::*;
#(
  parameter int SPEED_FRAC_BITS = SPEED_FRAC_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     s_tvalid,
  output logic     s_tready,
  input  logic     s_tuser,
  output logic     m_tvalid,
  input  logic     m_tready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);
  localparam int RTN = rt_steps(SPEED_FRAC_BITS);
  localparam int MW = prod_bits(SPEED_FRAC_BITS);
  localparam int CW = $clog2(MW);

  typedef enum logic [15:0] {
    ST_IDLE = 16'h0001, ST_PKT = 16'h0002, ST_SQX = 16'h0004, ST_SQY = 16'h0008,
    ST_RTI = 16'h0010, ST_RT = 16'h0020, ST_NUM1 = 16'h0040, ST_NUM2 = 16'h0080,
    ST_MUL = 16'h0100, ST_DVI = 16'h0200, ST_DV = 16'h0400, ST_UPD = 16'h0800,
    ST_EMOT = 16'h1000, ST_BTN = 16'h2000, ST_CLMP = 16'h4000, ST_ECLMP = 16'h8000
  } state_t;

  state_t state, state_next;
  logic [1:0] bytes_held, bytes_held_next;
  logic [CW-1:0] cnt, cnt_next;
  logic axis, axis_next;
  logic out_valid, out_valid_next;
  logic out_free, s_acc;

  assign s_tready = state == ST_IDLE;
  assign s_acc = s_tvalid && s_tready;
  assign out_free = !out_valid || m_tready;
  assign m_tvalid = out_valid;

  // next state and datapath commands
  always_comb begin
    state_next = state;
    bytes_held_next = bytes_held;
    cnt_next = cnt;
    axis_next = axis;
    cmd.op = OP_NONE;
    cmd.axis = axis;
    cmd.load_out = 1'b0;
    cmd.kind = EV_MOTION;
    cmd.last = 1'b1;
    unique case (state)
      ST_IDLE: begin
        if (s_acc) begin
          if (s_tuser) begin
            state_next = ST_CLMP;
          end else begin
            unique case (bytes_held)
              2'd0: begin
                cmd.op = OP_HDR;
                bytes_held_next = 2'd1;
              end
              2'd1: begin
                cmd.op = OP_DXB;
                bytes_held_next = 2'd2;
              end
              default: begin
                cmd.op = OP_DYB;
                bytes_held_next = 2'd0;
                state_next = ST_PKT;
              end
            endcase
          end
        end
      end
      ST_PKT: state_next = stat.zero_motion ? ST_BTN : ST_SQX;
      ST_SQX: begin
        cmd.op = OP_SQX;
        axis_next = 1'b0;
        state_next = ST_SQY;
      end
      ST_SQY: begin
        cmd.op = OP_SQY;
        state_next = ST_RTI;
      end
      ST_RTI: begin
        cmd.op = OP_RTI;
        cnt_next = '0;
        state_next = ST_RT;
      end
      ST_RT: begin
        cmd.op = OP_RTS;
        cnt_next = cnt + 1'b1;
        if (cnt == CW'(RTN - 1)) state_next = ST_NUM1;
      end
      ST_NUM1: begin
        cmd.op = OP_NUM1;
        state_next = ST_NUM2;
      end
      ST_NUM2: begin
        cmd.op = OP_NUM2;
        state_next = ST_MUL;
      end
      ST_MUL: begin
        cmd.op = OP_MUL;
        state_next = ST_DVI;
      end
      ST_DVI: begin
        cmd.op = OP_DVI;
        cnt_next = '0;
        state_next = ST_DV;
      end
      ST_DV: begin
        cmd.op = OP_DVS;
        cnt_next = cnt + 1'b1;
        if (cnt == CW'(MW - 1)) state_next = ST_UPD;
      end
      ST_UPD: begin
        cmd.op = OP_UPD;
        if (!axis) begin
          axis_next = 1'b1;
          state_next = ST_MUL;
        end else begin
          state_next = ST_EMOT;
        end
      end
      ST_EMOT: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          cmd.last = !stat.btn_change;
          state_next = ST_BTN;
        end
      end
      ST_BTN: begin
        if (!stat.btn_change) begin
          state_next = ST_IDLE;
        end else if (out_free) begin
          cmd.op = OP_BTN;
          cmd.load_out = 1'b1;
          cmd.kind = stat.btn_new ? EV_DOWN : EV_UP;
          state_next = ST_IDLE;
        end
      end
      ST_CLMP: begin
        if (stat.moved) begin
          cmd.op = OP_CLAMP;
          state_next = ST_ECLMP;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_ECLMP: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
    out_valid_next = cmd.load_out ? 1'b1 : (m_tready ? 1'b0 : out_valid);
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      bytes_held <= '0;
      cnt <= '0;
      axis <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      bytes_held <= bytes_held_next;
      cnt <= cnt_next;
      axis <= axis_next;
      out_valid <= out_valid_next;
    end
  end

  `PS2MC_NEVER(a_no_clobber, clk, rst, cmd.load_out && out_valid && !m_tready, "result overwritten")
  `PS2MC_NEVER(a_held_range, clk, rst, bytes_held == 2'd3, "packet byte count out of range")
  `PS2MC_ASSERT(a_screen_cmd, clk, rst, s_acc && s_tuser |=> state == ST_CLMP, "screen beat lost")
endmodule

// ===== sv/ps2_mouse_packet_to_cursor_core.sv =====
// PS/2 mouse packet decoder with pointer acceleration: top level
//
// Usage: input beats on s_* carry one mouse stream byte (s_tuser = 0) or a
// screen-changed command (s_tuser = 1). Every third stream byte closes a
// packet; it yields a motion event when the delta is non-zero and a button
// down/up event when the left button changed. A screen-changed command
// re-clamps the pointer and yields a motion event only if it moved.
// Events leave on m_*, m_tlast marks the final event of an input beat.
// Header and dx bytes are stored as they are accepted. A dy byte with
// motion runs the one-bit-per-cycle square root and the shared restoring
// divider, which runs once for x and once for y, before the next beat is
// accepted; a dy byte with zero motion skips both.
// Results sit in an output register; the next beat is accepted while it
// waits. If the receiver stalls with a second event pending, the block
// holds and s_tready stays low until the register frees up.
// Reset (rst, synchronous) restores register defaults, empties the packet
// assembly, centers the pointer in a 640 x 480 screen, releases the button.
// Configuration beats are taken every cycle and should be sent while idle.
`timescale 1ns / 1ps
module ps2_mouse_packet_to_cursor_core
  import ps2mc_pkg::*;
#(
  parameter int POS_BITS = POS_BITS_DEF,
  parameter int SPEED_FRAC_BITS = SPEED_FRAC_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [7:0]       s_tdata,    // data_byte
  input  logic             s_tuser,    // cmd
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [31:0]      m_tdata,    // pointer_x, pointer_y, button_state, zero pad
  output logic [1:0]       m_tuser,    // event_kind
  output logic             m_tlast,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [2:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);
  dp_cmd_t cmd;
  dp_stat_t stat;
  logic [11:0] px, py;
  logic pbtn;

  assign cfg_ready = 1'b1;
  assign m_tdata = {7'd0, pbtn, py, px};

  ps2mc_ctrl #(
    .SPEED_FRAC_BITS(SPEED_FRAC_BITS)
  ) u_ctrl (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .stat(stat),
    .cmd(cmd)
  );

  ps2mc_datapath #(
    .POS_BITS(POS_BITS),
    .SPEED_FRAC_BITS(SPEED_FRAC_BITS)
  ) u_dp (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_valid && cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_byte(s_tdata),
    .cmd(cmd),
    .stat(stat),
    .out_kind(m_tuser),
    .out_x(px),
    .out_y(py),
    .out_btn(pbtn),
    .out_last(m_tlast)
  );
endmodule
